### src/rc4kc_pkg.sv
// Shared types and constants for the RC4 keystream cipher.
// Used by rc4kc_ctrl, rc4kc_dp and the rc4_keystream_cipher top level.
package rc4kc_pkg;

    // Table and key geometry
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TBL_DEPTH  = 256;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned KEY_REGS   = 4;
    localparam int unsigned KEY_REG_W  = 64;
    localparam int unsigned KLEN_W     = 6;
    // Key length compare width: holds any MAX_KEY_BYTES up to 256
    localparam int unsigned LEN_CMP_W  = 9;
    localparam int unsigned CFG_ADDR_W = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_0   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_1   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_2   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_3   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEN = 3'd4;

    // Input word kinds carried in tuser
    localparam logic ACT_REKEY  = 1'b0;
    localparam logic ACT_CIPHER = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_INIT,
        ST_KS_RDN,
        ST_KS_RDA,
        ST_KS_WRN,
        ST_KS_WRA,
        ST_PR_RDJ,
        ST_PR_RDT,
        ST_PR_OUT
    } t_state;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_KS_INIT,
        OP_KS_RDN,
        OP_KS_RDA,
        OP_KS_WRN,
        OP_KS_WRA,
        OP_PR_RDJ,
        OP_PR_RDT,
        OP_PR_OUT
    } t_dp_op;

    // Controller to datapath command
    typedef struct packed {
        logic   latch;    // capture the accepted input word
        logic   fetch_i;  // advance i and read S[i]
        t_dp_op op;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_zero;   // key length register is zero
        logic step_last;  // key schedule is on its final step
        logic out_valid;  // output register holds a word
    } t_sts;

endpackage

### src/rc4_keystream_cipher.sv
// RC4 keystream cipher top level: joins controller and datapath.
// Depends on rc4kc_pkg, rc4kc_ctrl and rc4kc_dp.
//
//  channel  dir  handshake            payload
//  s        in   i_s_tvalid/o_s_tready tdata=data_in, tlast=end_of_buffer, tuser=action
//  m        out  o_m_tvalid/i_m_tready tdata=data_out, tlast=last_byte
//  cfg      in   i_cfg_we             i_cfg_addr index, i_cfg_wdata value
//
// A cipher word runs PR_RDJ, PR_RDT and PR_OUT after it is accepted; the single read
// port of the permutation memory serves three dependent reads per byte. A rekey word
// runs KS_INIT, then 256 steps of KS_RDN/RDA/WRN/WRA; an empty key runs KS_INIT alone.
// No clearing pass after reset: per-entry valid bits give the reset table.
// A full output register stalls the final cycle of a cipher word until taken.
module rc4_keystream_cipher #(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rc4kc_pkg::BYTE_W-1:0]      i_s_tdata,   // [7:0] data_in
    input  logic                              i_s_tlast,
    input  logic                              i_s_tuser,   // [0] action
    // stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rc4kc_pkg::BYTE_W-1:0]      o_m_tdata,   // [7:0] data_out
    output logic                              o_m_tlast,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rc4kc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rc4kc_pkg::KEY_REG_W-1:0]   i_cfg_wdata
);

    rc4kc_pkg::t_cmd cmd;
    rc4kc_pkg::t_sts sts;

    rc4kc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    rc4kc_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_m_tready  (i_m_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

### src/rc4kc_ctrl.sv
// Controller state machine for the RC4 keystream cipher.
// Depends on rc4kc_pkg; drives rc4kc_dp through t_cmd and reads t_sts.
module rc4kc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_action,
    input  logic              i_m_tready,
    input  rc4kc_pkg::t_sts   i_sts,
    output logic              o_s_tready,
    output rc4kc_pkg::t_cmd   o_cmd
);

    rc4kc_pkg::t_state r_state;
    rc4kc_pkg::t_state n_state;
    logic              out_free;
    logic              take;

    assign out_free = !i_sts.out_valid || i_m_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc4kc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd.op      = rc4kc_pkg::OP_NONE;
        unique case (r_state)
            rc4kc_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            rc4kc_pkg::ST_KS_INIT: begin
                o_cmd.op = rc4kc_pkg::OP_KS_INIT;
                n_state  = i_sts.len_zero ? rc4kc_pkg::ST_IDLE : rc4kc_pkg::ST_KS_RDN;
            end
            rc4kc_pkg::ST_KS_RDN: begin
                o_cmd.op = rc4kc_pkg::OP_KS_RDN;
                n_state  = rc4kc_pkg::ST_KS_RDA;
            end
            rc4kc_pkg::ST_KS_RDA: begin
                o_cmd.op = rc4kc_pkg::OP_KS_RDA;
                n_state  = rc4kc_pkg::ST_KS_WRN;
            end
            rc4kc_pkg::ST_KS_WRN: begin
                o_cmd.op = rc4kc_pkg::OP_KS_WRN;
                n_state  = rc4kc_pkg::ST_KS_WRA;
            end
            rc4kc_pkg::ST_KS_WRA: begin
                o_cmd.op = rc4kc_pkg::OP_KS_WRA;
                n_state  = i_sts.step_last ? rc4kc_pkg::ST_IDLE : rc4kc_pkg::ST_KS_RDN;
            end
            rc4kc_pkg::ST_PR_RDJ: begin
                o_cmd.op = rc4kc_pkg::OP_PR_RDJ;
                n_state  = rc4kc_pkg::ST_PR_RDT;
            end
            rc4kc_pkg::ST_PR_RDT: begin
                o_cmd.op = rc4kc_pkg::OP_PR_RDT;
                n_state  = rc4kc_pkg::ST_PR_OUT;
            end
            rc4kc_pkg::ST_PR_OUT: begin
                // hold until the output register can take the word
                if (out_free) begin
                    o_cmd.op   = rc4kc_pkg::OP_PR_OUT;
                    o_s_tready = 1'b1;
                    n_state    = rc4kc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rc4kc_pkg::ST_IDLE;
            end
        endcase

        // Start the next word straight away when one is accepted
        take          = i_s_tvalid && o_s_tready;
        o_cmd.latch   = take;
        o_cmd.fetch_i = take && (i_action == rc4kc_pkg::ACT_CIPHER);
        if (take) begin
            n_state = (i_action == rc4kc_pkg::ACT_CIPHER) ? rc4kc_pkg::ST_PR_RDJ
                                                          : rc4kc_pkg::ST_KS_INIT;
        end
    end

`ifndef NO_ASSERTIONS
    a_ks_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4kc_pkg::ST_KS_WRA && !i_sts.step_last)
        |=> (r_state == rc4kc_pkg::ST_KS_RDN))
        else $error("key schedule left its loop early");

    a_cipher_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_action == rc4kc_pkg::ACT_CIPHER)
        |=> (r_state == rc4kc_pkg::ST_PR_RDJ))
        else $error("accepted cipher word did not start generator");
`endif

endmodule

### src/rc4kc_dp.sv
// Datapath for the RC4 keystream cipher: key registers, permutation memory,
// indices and output register. Depends on rc4kc_pkg; driven by rc4kc_ctrl.
module rc4kc_dp #(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rc4kc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rc4kc_pkg::KEY_REG_W-1:0]      i_cfg_wdata,
    input  logic [rc4kc_pkg::BYTE_W-1:0]         i_data,
    input  logic                                 i_last,
    input  logic                                 i_m_tready,
    input  rc4kc_pkg::t_cmd                      i_cmd,
    output rc4kc_pkg::t_sts                      o_sts,
    output logic                                 o_m_tvalid,
    output logic [rc4kc_pkg::BYTE_W-1:0]         o_m_tdata,
    output logic                                 o_m_tlast
);

    localparam logic [rc4kc_pkg::LEN_CMP_W-1:0] MAX_LEN =
        rc4kc_pkg::LEN_CMP_W'(MAX_KEY_BYTES);

    // Key registers
    logic [rc4kc_pkg::KEY_REG_W-1:0] r_key [rc4kc_pkg::KEY_REGS];
    logic [rc4kc_pkg::KLEN_W-1:0]    r_key_len;

    // Permutation memory with per-entry valid bits
    logic [rc4kc_pkg::BYTE_W-1:0]    r_mem [rc4kc_pkg::TBL_DEPTH];
    logic [rc4kc_pkg::TBL_DEPTH-1:0] r_vld;
    logic                            r_ident;
    logic [rc4kc_pkg::BYTE_W-1:0]    r_rd_mem;
    logic                            r_rd_vld;
    logic [rc4kc_pkg::ADDR_W-1:0]    r_rd_addr;

    // Indices and working registers
    logic [rc4kc_pkg::ADDR_W-1:0]    r_i;
    logic [rc4kc_pkg::ADDR_W-1:0]    r_j;
    logic [rc4kc_pkg::BYTE_W-1:0]    r_si;
    logic [rc4kc_pkg::BYTE_W-1:0]    r_sj;
    logic [rc4kc_pkg::ADDR_W-1:0]    r_t;
    logic [rc4kc_pkg::ADDR_W-1:0]    r_kpos;
    logic [rc4kc_pkg::BYTE_W-1:0]    r_data;
    logic                            r_last;

    // Output register
    logic                            r_out_valid;
    logic [rc4kc_pkg::BYTE_W-1:0]    r_out_data;
    logic                            r_out_last;

    logic [rc4kc_pkg::BYTE_W-1:0]    rd_val;
    logic [rc4kc_pkg::BYTE_W-1:0]    key_byte;
    logic [rc4kc_pkg::LEN_CMP_W-1:0] len_raw;
    logic [rc4kc_pkg::LEN_CMP_W-1:0] len_eff;
    logic [rc4kc_pkg::LEN_CMP_W-1:0] kpos_inc;
    logic [rc4kc_pkg::ADDR_W-1:0]    kpos_next;
    logic [rc4kc_pkg::ADDR_W-1:0]    acc_next;
    logic [rc4kc_pkg::ADDR_W-1:0]    j_next;
    logic [rc4kc_pkg::ADDR_W-1:0]    t_next;
    logic [rc4kc_pkg::BYTE_W-1:0]    ks;
    logic                            len_zero;
    logic                            rd_en;
    logic [rc4kc_pkg::ADDR_W-1:0]    rd_addr;
    logic                            wr_en;
    logic [rc4kc_pkg::ADDR_W-1:0]    wr_addr;
    logic [rc4kc_pkg::BYTE_W-1:0]    wr_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]  <= '0;
            r_key[1]  <= '0;
            r_key[2]  <= '0;
            r_key[3]  <= '0;
            r_key_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rc4kc_pkg::CFG_KEY_0:   r_key[0]  <= i_cfg_wdata;
                rc4kc_pkg::CFG_KEY_1:   r_key[1]  <= i_cfg_wdata;
                rc4kc_pkg::CFG_KEY_2:   r_key[2]  <= i_cfg_wdata;
                rc4kc_pkg::CFG_KEY_3:   r_key[3]  <= i_cfg_wdata;
                rc4kc_pkg::CFG_KEY_LEN: r_key_len <= i_cfg_wdata[rc4kc_pkg::KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective key length saturates at MAX_KEY_BYTES; key positions wrap at the effective length
    assign len_raw   = {{(rc4kc_pkg::LEN_CMP_W-rc4kc_pkg::KLEN_W){1'b0}}, r_key_len};
    assign len_eff   = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    assign len_zero  = (r_key_len == '0);
    assign key_byte  = r_key[r_kpos[4:3]][{r_kpos[2:0], 3'b000} +: rc4kc_pkg::BYTE_W];
    assign kpos_inc  = {1'b0, r_kpos} + rc4kc_pkg::LEN_CMP_W'(1);
    assign kpos_next = (kpos_inc == len_eff) ? '0 : kpos_inc[rc4kc_pkg::ADDR_W-1:0];

    // Unwritten entries read as zero, or as their own address after a keyed init
    assign rd_val = r_rd_vld ? r_rd_mem : (r_ident ? r_rd_addr : '0);

    assign acc_next = r_j + rd_val + key_byte;
    assign j_next   = r_j + rd_val;
    assign t_next   = r_si + rd_val;

    // Keystream byte: S[i] and S[j] swap around the read of S[t]
    always_comb begin
        if (r_t == r_i) begin
            ks = r_sj;
        end else if (r_t == r_j) begin
            ks = r_si;
        end else begin
            ks = rd_val;
        end
    end

    // Memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_i;
        wr_en   = 1'b0;
        wr_addr = r_i;
        wr_data = rd_val;
        if (i_cmd.fetch_i) begin
            rd_en   = 1'b1;
            rd_addr = r_i + rc4kc_pkg::ADDR_W'(1);
        end
        unique case (i_cmd.op)
            rc4kc_pkg::OP_KS_RDN: begin
                rd_en   = 1'b1;
                rd_addr = r_i;
            end
            rc4kc_pkg::OP_KS_RDA: begin
                rd_en   = 1'b1;
                rd_addr = acc_next;
            end
            rc4kc_pkg::OP_KS_WRN: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = rd_val;
            end
            rc4kc_pkg::OP_KS_WRA: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_si;
            end
            rc4kc_pkg::OP_PR_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = j_next;
            end
            rc4kc_pkg::OP_PR_RDT: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_si;
                rd_en   = 1'b1;
                rd_addr = t_next;
            end
            rc4kc_pkg::OP_PR_OUT: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_sj;
            end
            default: ;
        endcase
    end

    // Permutation memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_mem  <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // Valid bits: clear on reset and on every rekey
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_ident <= 1'b0;
        end else if (i_cmd.op == rc4kc_pkg::OP_KS_INIT) begin
            r_vld   <= '0;
            r_ident <= !len_zero;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // Indices; during the key schedule i counts steps and j holds the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            case (i_cmd.op)
                rc4kc_pkg::OP_KS_INIT: begin
                    r_i <= '0;
                    r_j <= '0;
                end
                rc4kc_pkg::OP_KS_RDA: begin
                    r_j <= acc_next;
                end
                rc4kc_pkg::OP_KS_WRA: begin
                    r_i <= r_i + rc4kc_pkg::ADDR_W'(1);
                    if (o_sts.step_last) begin
                        r_j <= '0;
                    end
                end
                rc4kc_pkg::OP_PR_RDJ: begin
                    r_j <= j_next;
                end
                default: ;
            endcase
            if (i_cmd.fetch_i) begin
                r_i <= r_i + rc4kc_pkg::ADDR_W'(1);
            end
        end
    end

    // Working registers and captured input word
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rc4kc_pkg::OP_KS_INIT: r_kpos <= '0;
            rc4kc_pkg::OP_KS_RDA:  r_si   <= rd_val;
            rc4kc_pkg::OP_KS_WRA:  r_kpos <= kpos_next;
            rc4kc_pkg::OP_PR_RDJ:  r_si   <= rd_val;
            rc4kc_pkg::OP_PR_RDT: begin
                r_sj <= rd_val;
                r_t  <= t_next;
            end
            default: ;
        endcase
        if (i_cmd.latch) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == rc4kc_pkg::OP_PR_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rc4kc_pkg::OP_PR_OUT) begin
            r_out_data <= r_data ^ ks;
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_m_tlast       = r_out_last;
    assign o_sts.len_zero  = len_zero;
    assign o_sts.step_last = (r_i == {rc4kc_pkg::ADDR_W{1'b1}});
    assign o_sts.out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_ks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rc4kc_pkg::OP_KS_WRA && r_i == {rc4kc_pkg::ADDR_W{1'b1}})
        |=> (r_i == '0 && r_j == '0))
        else $error("indices not cleared after key schedule");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rc4kc_pkg::OP_PR_OUT) |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten while full");

    a_kpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rc4kc_pkg::OP_KS_RDA) |-> ({1'b0, r_kpos} < len_eff))
        else $error("key position beyond key length");

    a_fetch_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch_i |-> (i_cmd.op == rc4kc_pkg::OP_NONE
                           || i_cmd.op == rc4kc_pkg::OP_PR_OUT))
        else $error("read port claimed twice");
`endif

endmodule
